[rtl/core/cbb_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic bezier bounding box package
// Word format, pipeline depths and beat types shared by the bounding box core.
// ----------------------------------------------------------------------------
package cbb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;

	// Digit-by-digit square root: one result bit per stage over a radicand of
	// the word shifted up by the fraction bits.
	localparam int SQ_STEPS = (WORD_BITS + FRAC_BITS + 1) / 2;
	localparam int RAD_BITS = 2 * SQ_STEPS;
	localparam int REM_BITS = SQ_STEPS + 3;

	// Restoring divider: one quotient bit per stage.
	localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

	// Start-to-done latency of the whole pipeline in clock cycles.
	localparam int LATENCY = SQ_STEPS + DIV_STEPS + 9;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t FX_ONE = word_t'(64'd1 << FRAC_BITS);

	typedef struct packed {
		word_t x_c0;
		word_t x_c1;
		word_t x_c2;
		word_t x_c3;
		word_t y_c0;
		word_t y_c1;
		word_t y_c2;
		word_t y_c3;
	} in_t;

	typedef struct packed {
		word_t x_min;
		word_t x_max;
		word_t y_min;
		word_t y_max;
	} out_t;

	typedef struct packed {
		word_t c0;
		word_t c1;
		word_t c2;
		word_t c3;
	} coef_t;

	typedef struct packed {
		coef_t c;
		word_t lo;
		word_t hi;
		word_t nb;
		word_t den;
		logic  cond;
	} ctx_t;

endpackage

[rtl/core/cbb_axis.sv]
// ----------------------------------------------------------------------------
// Cubic bezier bounding box, one axis
// Pipelined extent of one power-basis cubic over t in [0, 1].
// ----------------------------------------------------------------------------
module cbb_axis (
	input  logic          clk,
	input  cbb_pkg::coef_t c,
	output cbb_pkg::word_t lo,
	output cbb_pkg::word_t hi
);

	localparam int W   = cbb_pkg::WORD_BITS;
	localparam int F   = cbb_pkg::FRAC_BITS;
	localparam int SQ  = cbb_pkg::SQ_STEPS;
	localparam int RB  = cbb_pkg::RAD_BITS;
	localparam int REM = cbb_pkg::REM_BITS;
	localparam int DV  = cbb_pkg::DIV_STEPS;

	// Fixed-point product: exact product, arithmetic shift, wrap to the word.
	function automatic cbb_pkg::word_t fx_mul(input cbb_pkg::word_t a, input cbb_pkg::word_t b);
		logic signed [2*W-1:0] p;
		p = a * b;
		return cbb_pkg::word_t'(p[F +: W]);
	endfunction

	// Stage 1: derivative coefficients, their products and the far endpoint.
	cbb_pkg::word_t a_c, b_c;
	cbb_pkg::coef_t c_s1;
	cbb_pkg::word_t bb_s1, ac_s1, e1_s1, b_s1, a_s1;

	assign a_c = c.c3 + (c.c3 <<< 1);
	assign b_c = c.c2 <<< 1;

	always_ff @(posedge clk) begin
		c_s1  <= c;
		bb_s1 <= fx_mul(b_c, b_c);
		ac_s1 <= fx_mul(a_c, c.c1);
		e1_s1 <= c.c0 + c.c1 + c.c2 + c.c3;
		b_s1  <= b_c;
		a_s1  <= a_c;
	end

	// Stage 2: discriminant, endpoint box and root conditions.
	cbb_pkg::word_t disc_c, den_c;
	cbb_pkg::ctx_t  ctx_c;

	assign disc_c = bb_s1 - (ac_s1 <<< 2);
	assign den_c  = a_s1 <<< 1;

	always_comb begin
		ctx_c.c    = c_s1;
		ctx_c.lo   = (c_s1.c0 < e1_s1) ? c_s1.c0 : e1_s1;
		ctx_c.hi   = (c_s1.c0 < e1_s1) ? e1_s1 : c_s1.c0;
		ctx_c.nb   = -b_s1;
		ctx_c.den  = den_c;
		ctx_c.cond = !disc_c[W-1] && (den_c != '0);
	end

	cbb_pkg::ctx_t  sq_ctx_s  [0:SQ];
	logic [REM-1:0] sq_rem_s  [0:SQ];
	logic [SQ-1:0]  sq_root_s [0:SQ];
	logic [RB-1:0]  sq_rad_s  [0:SQ];

	always_ff @(posedge clk) begin
		sq_ctx_s[0]  <= ctx_c;
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_rad_s[0]  <= RB'($unsigned(disc_c)) << F;
	end

	// Square root, one root bit per stage.
	for (genvar k = 0; k < SQ; k++) begin : g_sq
		logic [REM-1:0] cur, trial;
		assign cur   = {sq_rem_s[k][REM-3:0], sq_rad_s[k][RB-1 -: 2]};
		assign trial = REM'({sq_root_s[k], 2'b01});
		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				sq_rem_s[k+1]  <= cur - trial;
				sq_root_s[k+1] <= {sq_root_s[k][SQ-2:0], 1'b1};
			end else begin
				sq_rem_s[k+1]  <= cur;
				sq_root_s[k+1] <= {sq_root_s[k][SQ-2:0], 1'b0};
			end
			sq_rad_s[k+1] <= sq_rad_s[k] << 2;
			sq_ctx_s[k+1] <= sq_ctx_s[k];
		end
	end

	// Divider setup: both numerators and the divisor as magnitudes.
	cbb_pkg::ctx_t  dv_ctx_s [0:DV];
	logic [W-1:0]   dv_ud_s  [0:DV];
	logic [1:0]     dv_neg_s [0:DV];
	logic [W:0]     dv_r_s   [0:DV][2];
	logic [DV-1:0]  dv_nq_s  [0:DV][2];

	cbb_pkg::word_t root_w, num_c [2];
	logic [W-1:0]   un_c [2];
	logic [W-1:0]   ud_c;

	always_comb begin
		root_w   = cbb_pkg::word_t'(sq_root_s[SQ]);
		num_c[0] = sq_ctx_s[SQ].nb + root_w;
		num_c[1] = sq_ctx_s[SQ].nb - root_w;
		for (int j = 0; j < 2; j++) begin
			un_c[j] = num_c[j][W-1] ? W'(-num_c[j]) : W'(num_c[j]);
		end
		ud_c = sq_ctx_s[SQ].den[W-1] ? W'(-sq_ctx_s[SQ].den) : W'(sq_ctx_s[SQ].den);
	end

	always_ff @(posedge clk) begin
		dv_ctx_s[0] <= sq_ctx_s[SQ];
		dv_ud_s[0]  <= ud_c;
		for (int j = 0; j < 2; j++) begin
			dv_neg_s[0][j] <= num_c[j][W-1] ^ sq_ctx_s[SQ].den[W-1];
			dv_r_s[0][j]   <= '0;
			dv_nq_s[0][j]  <= DV'(un_c[j]) << F;
		end
	end

	// Restoring division, one quotient bit per stage; the quotient shifts in
	// where the numerator shifts out.
	for (genvar k = 0; k < DV; k++) begin : g_dv
		logic [W:0] cur [2];
		logic       ge  [2];
		always_comb begin
			for (int j = 0; j < 2; j++) begin
				cur[j] = {dv_r_s[k][j][W-1:0], dv_nq_s[k][j][DV-1]};
				ge[j]  = cur[j] >= {1'b0, dv_ud_s[k]};
			end
		end
		always_ff @(posedge clk) begin
			for (int j = 0; j < 2; j++) begin
				dv_r_s[k+1][j]  <= ge[j] ? cur[j] - {1'b0, dv_ud_s[k]} : cur[j];
				dv_nq_s[k+1][j] <= {dv_nq_s[k][j][DV-2:0], ge[j]};
			end
			dv_ud_s[k+1]  <= dv_ud_s[k];
			dv_neg_s[k+1] <= dv_neg_s[k];
			dv_ctx_s[k+1] <= dv_ctx_s[k];
		end
	end

	// Signed roots and the range test.
	logic [DV-1:0]  qn_c [2];
	cbb_pkg::word_t t_c  [2];
	logic           ok_c [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			qn_c[j] = dv_neg_s[DV][j] ? -dv_nq_s[DV][j] : dv_nq_s[DV][j];
			t_c[j]  = cbb_pkg::word_t'(qn_c[j][W-1:0]);
			ok_c[j] = dv_ctx_s[DV].cond && !t_c[j][W-1] && (t_c[j] <= cbb_pkg::FX_ONE);
		end
	end

	cbb_pkg::ctx_t  tq_ctx_s;
	cbb_pkg::word_t tq_t_s [2];
	logic           tq_ok_s [2];

	always_ff @(posedge clk) begin
		tq_ctx_s <= dv_ctx_s[DV];
		tq_t_s   <= t_c;
		tq_ok_s  <= ok_c;
	end

	// Cubic evaluation at both roots, one multiply deep per stage.
	cbb_pkg::ctx_t  e1_ctx_s, e2_ctx_s, e3_ctx_s, e4_ctx_s;
	cbb_pkg::word_t e1_t_s [2], e1_t2_s [2], e1_m1_s [2];
	cbb_pkg::word_t e2_t3_s [2], e2_m2_s [2], e2_acc_s [2];
	cbb_pkg::word_t e3_m3_s [2], e3_acc_s [2];
	cbb_pkg::word_t e4_v_s [2];
	logic           e1_ok_s [2], e2_ok_s [2], e3_ok_s [2], e4_ok_s [2];

	always_ff @(posedge clk) begin
		e1_ctx_s <= tq_ctx_s;
		e2_ctx_s <= e1_ctx_s;
		e3_ctx_s <= e2_ctx_s;
		e4_ctx_s <= e3_ctx_s;
		e1_ok_s  <= tq_ok_s;
		e2_ok_s  <= e1_ok_s;
		e3_ok_s  <= e2_ok_s;
		e4_ok_s  <= e3_ok_s;
		for (int j = 0; j < 2; j++) begin
			e1_t_s[j]   <= tq_t_s[j];
			e1_t2_s[j]  <= fx_mul(tq_t_s[j], tq_t_s[j]);
			e1_m1_s[j]  <= fx_mul(tq_ctx_s.c.c1, tq_t_s[j]);
			e2_t3_s[j]  <= fx_mul(e1_t2_s[j], e1_t_s[j]);
			e2_m2_s[j]  <= fx_mul(e1_ctx_s.c.c2, e1_t2_s[j]);
			e2_acc_s[j] <= e1_ctx_s.c.c0 + e1_m1_s[j];
			e3_m3_s[j]  <= fx_mul(e2_ctx_s.c.c3, e2_t3_s[j]);
			e3_acc_s[j] <= e2_acc_s[j] + e2_m2_s[j];
			e4_v_s[j]   <= e3_acc_s[j] + e3_m3_s[j];
		end
	end

	// Final stage: widen the endpoint box by the roots that qualify.
	cbb_pkg::word_t lo_c, hi_c, lo_s, hi_s;

	always_comb begin
		lo_c = e4_ctx_s.lo;
		hi_c = e4_ctx_s.hi;
		for (int j = 0; j < 2; j++) begin
			if (e4_ok_s[j]) begin
				if (e4_v_s[j] < lo_c) lo_c = e4_v_s[j];
				if (e4_v_s[j] > hi_c) hi_c = e4_v_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s <= lo_c;
		hi_s <= hi_c;
	end

	assign lo = lo_s;
	assign hi = hi_s;

endmodule

[rtl/core/cubic_bezier_bounding_box.sv]
// ----------------------------------------------------------------------------
// Cubic bezier bounding box
// Axis-aligned box of one cubic segment per beat, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   -------------------------  ------------------------------------
//  input     coeffs (x/y c0..c3)        beat taken when start && !busy
//  result    box (x/y min/max)          valid for one cycle while done is high
//
// The depth of the pipeline, cbb_pkg::LATENCY, is set by the bit-per-stage
// square root and the bit-per-stage restoring dividers. A new beat may be
// taken in every cycle, so the sustained rate is one segment per clock.
// Reset clears only the valid pipe; data stages carry no reset. The result
// side cannot stall, so busy stays low and the pipeline never holds.
//
module cubic_bezier_bounding_box (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cbb_pkg::in_t   coeffs,
	output logic           done,
	output cbb_pkg::out_t  box
);

	localparam int LAT = cbb_pkg::LATENCY;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// The valid bit of each beat walks alongside its data through both axes.
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	assign done = vld_q[LAT-1];

	// The two axes are independent and run in lockstep.
	cbb_pkg::coef_t cx, cy;
	cbb_pkg::word_t x_lo, x_hi, y_lo, y_hi;

	assign cx.c0 = coeffs.x_c0;
	assign cx.c1 = coeffs.x_c1;
	assign cx.c2 = coeffs.x_c2;
	assign cx.c3 = coeffs.x_c3;
	assign cy.c0 = coeffs.y_c0;
	assign cy.c1 = coeffs.y_c1;
	assign cy.c2 = coeffs.y_c2;
	assign cy.c3 = coeffs.y_c3;

	cbb_axis u_x (
		.clk (clk),
		.c   (cx),
		.lo  (x_lo),
		.hi  (x_hi)
	);

	cbb_axis u_y (
		.clk (clk),
		.c   (cy),
		.lo  (y_lo),
		.hi  (y_hi)
	);

	assign box.x_min = x_lo;
	assign box.x_max = x_hi;
	assign box.y_min = y_lo;
	assign box.y_max = y_hi;

`ifndef SYNTH
	// A result appears only for a matching accepted input beat.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching input beat");

	// Every accepted beat produces its result.
	a_beat_completes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("input beat lost in the pipeline");

	// The box is never inverted on either axis.
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (box.x_min <= box.x_max) && (box.y_min <= box.y_max))
		else $error("bounding box min exceeds max");
`endif

endmodule
